[src/ordered_key_value_table_macros.svh]
// Assertion macros for the ordered key-value table.
// Used by the controller; no other dependencies.
`ifndef ORDERED_KEY_VALUE_TABLE_MACROS_SVH
`define ORDERED_KEY_VALUE_TABLE_MACROS_SVH

`ifndef SYNTH

`define OKVT_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("okvt: same-cycle check failed");

`define OKVT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("okvt: next-cycle check failed");

`else

`define OKVT_ASSERT_IMPL(label, clk, rstn, ante, cons)

`define OKVT_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

[src/okvt_pkg.sv]
// Shared constants, opcodes and request/result types of the ordered key-value table.
// No dependencies.
package okvt_pkg;

    localparam int ENTRIES    = 16;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int ENT_W = KEY_BITS + VALUE_BITS;

    localparam int OP_W      = 3;
    localparam int KEY_W     = 32;
    localparam int VAL_W     = 32;
    localparam int IDX_IN_W  = 4;
    localparam int CNT_OUT_W = 5;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT     = 3'd0,
        OP_UPDATE     = 3'd1,
        OP_INS_OR_UPD = 3'd2,
        OP_ERASE      = 3'd3,
        OP_LOOKUP     = 3'd4,
        OP_READ_INDEX = 3'd5
    } op_t;

    typedef struct packed {
        logic [OP_W-1:0]       op;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] val;
        logic [IDX_IN_W-1:0]   index;
    } req_t;

    typedef struct packed {
        logic                 ok;
        logic [KEY_W-1:0]     key;
        logic [VAL_W-1:0]     val;
        logic [CNT_OUT_W-1:0] count;
    } res_t;

endpackage

[src/okvt_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module okvt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

[src/okvt_ctrl.sv]
// Request sequencer: key scan, insert/update write-back and erase compaction over the entry RAM.
// Depends on okvt_pkg, okvt_ram and the assertion macro header.
`include "ordered_key_value_table_macros.svh"

module okvt_ctrl
    import okvt_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic res_valid,
    input  logic res_ready,
    output res_t res
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_SEARCH = 6'b000010,
        ST_IDX_RD = 6'b000100,
        ST_ACT    = 6'b001000,
        ST_SHIFT  = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

    state_t                state_reg, state_next;
    logic [OP_W-1:0]       op_reg, op_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic [IDX_IN_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      scan_reg, scan_next;
    logic                  chk_valid_reg, chk_valid_next;
    logic [IDX_W-1:0]      chk_addr_reg, chk_addr_next;
    logic                  found_reg, found_next;
    logic [IDX_W-1:0]      pos_reg, pos_next;
    logic [VALUE_BITS-1:0] ent_val_reg, ent_val_next;
    res_t                  res_reg, res_next;

    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [ENT_W-1:0]      wr_data;
    logic [IDX_W-1:0]      rd_addr;
    logic [ENT_W-1:0]      rd_data;
    logic [KEY_BITS-1:0]   rd_key;
    logic [VALUE_BITS-1:0] rd_val;
    logic                  issue;
    logic                  full;
    logic                  idx_ok;

    okvt_ram #(
        .WIDTH(ENT_W),
        .DEPTH(ENTRIES)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_key    = rd_data[ENT_W-1:VALUE_BITS];
    assign rd_val    = rd_data[VALUE_BITS-1:0];
    assign issue     = scan_reg < count_reg;
    assign full      = count_reg == CNT_W'(ENTRIES);
    assign idx_ok    = 32'(idx_reg) < 32'(count_reg);
    assign req_ready = state_reg == ST_IDLE;
    assign res_valid = state_reg == ST_DONE;
    assign res       = res_reg;

    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        val_next       = val_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        scan_next      = scan_reg;
        chk_valid_next = chk_valid_reg;
        chk_addr_next  = chk_addr_reg;
        found_next     = found_reg;
        pos_next       = pos_reg;
        ent_val_next   = ent_val_reg;
        res_next       = res_reg;
        wr_en          = 1'b0;
        wr_addr        = count_reg[IDX_W-1:0];
        wr_data        = {key_reg, val_reg};
        rd_addr        = scan_reg[IDX_W-1:0];

        unique case (state_reg)
            ST_IDLE: begin
                if (req_valid) begin
                    op_next        = req.op;
                    key_next       = req.key;
                    val_next       = req.val;
                    idx_next       = req.index;
                    scan_next      = '0;
                    chk_valid_next = 1'b0;
                    found_next     = 1'b0;
                    unique case (req.op)
                        OP_INSERT, OP_UPDATE, OP_INS_OR_UPD, OP_ERASE, OP_LOOKUP: begin
                            state_next = ST_SEARCH;
                        end
                        OP_READ_INDEX: begin
                            state_next = ST_IDX_RD;
                        end
                        default: begin
                            state_next = ST_ACT;
                        end
                    endcase
                end
            end
            ST_SEARCH: begin
                // one entry read per cycle, compared in the next cycle
                if (chk_valid_reg && rd_key == key_reg) begin
                    found_next   = 1'b1;
                    pos_next     = chk_addr_reg;
                    ent_val_next = rd_val;
                    state_next   = ST_ACT;
                end else if (!issue) begin
                    found_next = 1'b0;
                    state_next = ST_ACT;
                end else begin
                    chk_valid_next = 1'b1;
                    chk_addr_next  = scan_reg[IDX_W-1:0];
                    scan_next      = scan_reg + CNT_W'(1);
                end
            end
            ST_IDX_RD: begin
                rd_addr    = IDX_W'(idx_reg);
                state_next = ST_ACT;
            end
            ST_ACT: begin
                res_next.ok  = 1'b0;
                res_next.key = '0;
                res_next.val = '0;
                state_next   = ST_DONE;
                unique case (op_reg)
                    OP_INSERT: begin
                        if (!found_reg && !full) begin
                            wr_en       = 1'b1;
                            count_next  = count_reg + CNT_W'(1);
                            res_next.ok = 1'b1;
                        end
                    end
                    OP_UPDATE: begin
                        if (found_reg) begin
                            wr_en       = 1'b1;
                            wr_addr     = pos_reg;
                            res_next.ok = 1'b1;
                        end
                    end
                    OP_INS_OR_UPD: begin
                        if (found_reg) begin
                            wr_en       = 1'b1;
                            wr_addr     = pos_reg;
                            res_next.ok = 1'b1;
                        end else if (!full) begin
                            wr_en       = 1'b1;
                            count_next  = count_reg + CNT_W'(1);
                            res_next.ok = 1'b1;
                        end
                    end
                    OP_ERASE: begin
                        if (found_reg) begin
                            scan_next      = CNT_W'(pos_reg) + CNT_W'(1);
                            chk_valid_next = 1'b0;
                            state_next     = ST_SHIFT;
                        end
                    end
                    OP_LOOKUP: begin
                        if (found_reg) begin
                            res_next.ok  = 1'b1;
                            res_next.val = VAL_W'(ent_val_reg);
                        end
                    end
                    OP_READ_INDEX: begin
                        if (idx_ok) begin
                            res_next.ok  = 1'b1;
                            res_next.key = KEY_W'(rd_key);
                            res_next.val = VAL_W'(rd_val);
                        end
                    end
                    default: begin
                    end
                endcase
                res_next.count = CNT_OUT_W'(count_next);
            end
            ST_SHIFT: begin
                // read entry n, write it to n-1 in the next cycle
                if (chk_valid_reg) begin
                    wr_en   = 1'b1;
                    wr_addr = chk_addr_reg - IDX_W'(1);
                    wr_data = rd_data;
                end
                if (!issue) begin
                    count_next     = count_reg - CNT_W'(1);
                    res_next.ok    = 1'b1;
                    res_next.count = CNT_OUT_W'(count_reg - CNT_W'(1));
                    state_next     = ST_DONE;
                end else begin
                    chk_valid_next = 1'b1;
                    chk_addr_next  = scan_reg[IDX_W-1:0];
                    scan_next      = scan_reg + CNT_W'(1);
                end
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            chk_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            chk_valid_reg <= chk_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        key_reg      <= key_next;
        val_reg      <= val_next;
        idx_reg      <= idx_next;
        scan_reg     <= scan_next;
        chk_addr_reg <= chk_addr_next;
        found_reg    <= found_next;
        pos_reg      <= pos_next;
        ent_val_reg  <= ent_val_next;
        res_reg      <= res_next;
    end

    `OKVT_ASSERT_IMPL(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_W'(ENTRIES))
    `OKVT_ASSERT_IMPL(a_write_phase, aclk, aresetn, wr_en, state_reg == ST_ACT || state_reg == ST_SHIFT)
    `OKVT_ASSERT_NEXT(a_scan_keeps_count, aclk, aresetn, state_reg == ST_SEARCH, $stable(count_reg))
    `OKVT_ASSERT_NEXT(a_accept_busy, aclk, aresetn, req_valid && req_ready, !req_ready)

endmodule

[src/ordered_key_value_table.sv]
// Top level of the ordered key-value table: port mapping and result output register.
// Depends on okvt_pkg and okvt_ctrl.

// Bounded key-value table (ENTRIES entries) kept in insertion order, one request
// at a time, one result per request. Entries live in a single RAM with one read
// and one write port; keys are found by scanning it one entry per cycle. Insert,
// update, insert-or-update, lookup and erase scan for the key, stopping at a match,
// then act on it; erase of a present key then moves the later entries down. Read by
// index reads the entry directly, and unused opcodes fail without a scan. The next
// request is accepted from the cycle after the result enters the output register.
// The RAM needs no clearing after reset. A result waiting in the output register
// does not stop the next request from being accepted.
module ordered_key_value_table
    import okvt_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [OP_W-1:0]      s_opcode,
    input  logic [KEY_W-1:0]     s_req_key,
    input  logic [VAL_W-1:0]     s_req_value,
    input  logic [IDX_IN_W-1:0]  s_req_index,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_ok,
    output logic [KEY_W-1:0]     m_out_key,
    output logic [VAL_W-1:0]     m_out_value,
    output logic [CNT_OUT_W-1:0] m_entry_count_out
);

    req_t req;
    res_t res;
    logic res_valid;
    logic res_ready;
    logic m_valid_reg, m_valid_next;
    res_t m_res_reg, m_res_next;

    assign req.op    = s_opcode;
    assign req.key   = KEY_BITS'(s_req_key);
    assign req.val   = VALUE_BITS'(s_req_value);
    assign req.index = s_req_index;

    okvt_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_valid),
        .req_ready (s_ready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
            m_res_next   = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_res_reg <= m_res_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_ok              = m_res_reg.ok;
    assign m_out_key         = m_res_reg.key;
    assign m_out_value       = m_res_reg.val;
    assign m_entry_count_out = m_res_reg.count;

endmodule
